// ===== rtl/trmf_pkg.sv =====
// Shared types and constants for the tagged radio message FIFO.
`timescale 1ns / 1ps

package trmf_pkg;

   localparam int SLOTS     = 8;
   localparam int MSG_BYTES = 32;
   localparam int PIPE_MAX  = 5;

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int LEN_W   = $clog2(MSG_BYTES + 1);
   localparam int BYTE_DEPTH = SLOTS * MSG_BYTES;
   localparam int BYTE_AW = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;

   typedef enum logic [1:0] {
      ACT_PUSH_BYTE  = 2'd0,
      ACT_PUSH_EMPTY = 2'd1,
      ACT_POP        = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_TOO_LONG = 3'd2,
      STAT_BAD_PIPE = 3'd3,
      STAT_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_META,
      FSM_BYTES
   } fsm_state_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [2:0]  pipe;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic [2:0]  out_pipe;
      logic [5:0]  msg_length;
      logic        run_end;
      logic [3:0]  queued_count;
      logic        is_empty;
      logic        is_full;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic [2:0]       pipe;
   } meta_type;

endpackage

// ===== rtl/trmf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module trmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tagged_radio_message_fifo_unit.sv =====
// Top level of the tagged radio message FIFO: slot ring, push checks and pop streaming.
`timescale 1ns / 1ps

// Channel | Dir | Payload  | Handshake
// req     | in  | req_type | req_valid / req_stall
// rsp     | out | rsp_type | rsp_valid / rsp_stall
//
// Push-byte, push-empty and ignored items are handled in the idle state; a completing push
// loads its status transaction straight into the output register.
// A pop reads the slot record (idle, then META) and the first byte from the byte store (BYTES),
// then one byte per cycle as the output register frees; an empty pop loads its empty status directly.
// Reset clears pointers, counts and handshake state; slot contents stay undefined.
// rsp_stall holds the output register and, while it is full, stalls req.

module tagged_radio_message_fifo_unit
   import trmf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   fsm_state_type state_ff, state_in;
   logic [SLOT_W-1:0] head_ff, head_in, tail_ff, tail_in, pop_slot_ff, pop_slot_in;
   logic [CNT_W-1:0]  queued_ff, queued_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic              ovf_ff, ovf_in, drop_ff, drop_in;
   logic [LEN_W-1:0]  len_ff, len_in, rd_idx_ff, rd_idx_in, emit_idx_ff, emit_idx_in;
   logic [2:0]        pipe_ff, pipe_in;
   logic              data_pend_ff, data_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              byte_wr_en, byte_rd_en;
   logic [BYTE_AW-1:0] byte_wr_addr, byte_rd_addr;
   logic [7:0]        byte_rd_data;
   logic              meta_wr_en, meta_rd_en;
   meta_type          meta_wr_data, meta_rd_data;
   logic [LEN_W-1:0]  meta_len;

   logic              accept, out_free, full_now, store, drop_n, ovf_n, is_byte;
   logic              cmp_full, cmp_long, last_emit, load_byte;
   logic [LEN_W-1:0]  pos_n, cmp_len;
   status_type        cmp_status;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
   endfunction

   function automatic rsp_type make_rsp(input status_type st, input logic [7:0] b,
                                        input logic bv, input logic [2:0] p,
                                        input logic [LEN_W-1:0] l, input logic e,
                                        input logic [CNT_W-1:0] q);
      rsp_type r;
      r.status       = st;
      r.out_byte     = b;
      r.byte_valid   = bv;
      r.out_pipe     = p;
      r.msg_length   = 6'(l);
      r.run_end      = e;
      r.queued_count = 4'(q);
      r.is_empty     = (q == '0);
      r.is_full      = (q == CNT_W'(SLOTS));
      return r;
   endfunction

   trmf_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH)) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_wr_en),
      .wr_addr (byte_wr_addr),
      .wr_data (req_data.data_byte),
      .rd_en   (byte_rd_en),
      .rd_addr (byte_rd_addr),
      .rd_data (byte_rd_data)
   );

   trmf_ram #(.WIDTH($bits(meta_type)), .DEPTH(SLOTS)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (tail_ff),
      .wr_data (meta_wr_data),
      .rd_en   (meta_rd_en),
      .rd_addr (head_ff),
      .rd_data (meta_rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == FSM_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   assign full_now = (queued_ff == CNT_W'(SLOTS));
   assign store    = !full_now && (pos_ff < LEN_W'(MSG_BYTES));
   assign pos_n    = pos_ff + LEN_W'(store);
   assign drop_n   = drop_ff || full_now;
   assign ovf_n    = ovf_ff || (!full_now && !store);
   assign is_byte  = (req_data.action == ACT_PUSH_BYTE);
   assign cmp_full = is_byte ? drop_n : full_now;
   assign cmp_long = is_byte && ovf_n;
   assign cmp_len  = is_byte ? pos_n : '0;

   always_comb begin
      if (cmp_full) begin
         cmp_status = STAT_FULL;
      end else if (cmp_long) begin
         cmp_status = STAT_TOO_LONG;
      end else if (req_data.pipe > 3'(PIPE_MAX)) begin
         cmp_status = STAT_BAD_PIPE;
      end else begin
         cmp_status = STAT_OK;
      end
   end

   assign meta_len  = (meta_rd_data.length > LEN_W'(MSG_BYTES)) ? LEN_W'(MSG_BYTES)
                                                                 : meta_rd_data.length;
   assign last_emit = (emit_idx_ff == len_ff - LEN_W'(1));
   assign load_byte = (state_ff == FSM_BYTES) && (len_ff != '0) && data_pend_ff && out_free;

   assign byte_wr_addr = BYTE_AW'(tail_ff) * BYTE_AW'(MSG_BYTES) + BYTE_AW'(pos_ff);
   assign byte_rd_addr = BYTE_AW'(pop_slot_ff) * BYTE_AW'(MSG_BYTES) + BYTE_AW'(rd_idx_ff);
   assign meta_wr_data = '{length: cmp_len, pipe: req_data.pipe};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept && (req_data.action == ACT_POP) && (queued_ff != '0)) begin
               state_in = FSM_META;
            end
         end
         FSM_META: begin
            state_in = FSM_BYTES;
         end
         FSM_BYTES: begin
            if (out_free && ((len_ff == '0) || (data_pend_ff && last_emit))) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      pop_slot_in  = pop_slot_ff;
      queued_in    = queued_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      drop_in      = drop_ff;
      len_in       = len_ff;
      pipe_in      = pipe_ff;
      rd_idx_in    = rd_idx_ff;
      emit_idx_in  = emit_idx_ff;
      data_pend_in = data_pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      byte_wr_en   = 1'b0;
      byte_rd_en   = 1'b0;
      meta_wr_en   = 1'b0;
      meta_rd_en   = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_PUSH_BYTE, ACT_PUSH_EMPTY: begin
                     byte_wr_en = is_byte && store;
                     if (is_byte && !req_data.last_byte) begin
                        pos_in  = pos_n;
                        ovf_in  = ovf_n;
                        drop_in = drop_n;
                     end else begin
                        pos_in       = '0;
                        ovf_in       = 1'b0;
                        drop_in      = 1'b0;
                        rsp_valid_in = 1'b1;
                        if (cmp_status == STAT_OK) begin
                           meta_wr_en = 1'b1;
                           tail_in    = next_slot(tail_ff);
                           queued_in  = queued_ff + CNT_W'(1);
                           rsp_in     = make_rsp(STAT_OK, 8'd0, 1'b0, req_data.pipe,
                                                 cmp_len, 1'b1, queued_ff + CNT_W'(1));
                        end else begin
                           rsp_in = make_rsp(cmp_status, 8'd0, 1'b0, 3'd0, '0, 1'b1,
                                             queued_ff);
                        end
                     end
                  end
                  ACT_POP: begin
                     if (queued_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(STAT_EMPTY, 8'd0, 1'b0, 3'd0, '0, 1'b1, queued_ff);
                     end else begin
                        meta_rd_en  = 1'b1;
                        pop_slot_in = head_ff;
                        head_in     = next_slot(head_ff);
                        queued_in   = queued_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         FSM_META: begin
            len_in       = meta_len;
            pipe_in      = meta_rd_data.pipe;
            rd_idx_in    = '0;
            emit_idx_in  = '0;
            data_pend_in = 1'b0;
         end
         FSM_BYTES: begin
            if (len_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp(STAT_OK, 8'd0, 1'b0, pipe_ff, '0, 1'b1, queued_ff);
               end
            end else begin
               if (load_byte) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp(STAT_OK, byte_rd_data, 1'b1, pipe_ff, len_ff,
                                    last_emit, queued_ff);
                  emit_idx_in = emit_idx_ff + LEN_W'(1);
               end
               if ((rd_idx_ff < len_ff) && (!data_pend_ff || load_byte)) begin
                  byte_rd_en   = 1'b1;
                  rd_idx_in    = rd_idx_ff + LEN_W'(1);
                  data_pend_in = 1'b1;
               end else if (load_byte) begin
                  data_pend_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         queued_ff    <= '0;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         drop_ff      <= 1'b0;
         data_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         queued_ff    <= queued_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         drop_ff      <= drop_in;
         data_pend_ff <= data_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_slot_ff <= pop_slot_in;
      len_ff      <= len_in;
      pipe_ff     <= pipe_in;
      rd_idx_ff   <= rd_idx_in;
      emit_idx_ff <= emit_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_queued_bound: assert property (@(posedge clock) disable iff (reset)
      queued_ff <= CNT_W'(SLOTS))
      else $error("queued count above slot count");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.action == ACT_POP) && (queued_ff == '0)
      |=> rsp_valid && (rsp_data.status == STAT_EMPTY))
      else $error("pop on empty queue gave no empty status");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != FSM_IDLE) |-> req_stall)
      else $error("request accepted during a pop run");

   a_pend_bytes: assert property (@(posedge clock) disable iff (reset)
      data_pend_ff |-> (state_ff == FSM_BYTES))
      else $error("byte read pending outside the byte run");

endmodule

// ===== sim/tb_tagged_radio_message_fifo_unit.sv =====
// Self-checking testbench for the tagged radio message FIFO unit.
`timescale 1ns / 1ps

module tb_tagged_radio_message_fifo_unit;
   import trmf_pkg::*;

   localparam int RANDOM_ITEMS = 315;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int ROWS         = 23;

   typedef struct packed {
      req_type    item;
      logic [5:0] reps;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   localparam stim_row_type DIRECTED [ROWS] = '{
      '{'{ACT_POP, 8'h00, 1'b0, 3'd0}, 6'd1, 1'b1,
        '{STAT_EMPTY, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1, 4'd0, 1'b1, 1'b0}},
      '{'{ACT_PUSH_EMPTY, 8'h00, 1'b0, 3'd7}, 6'd1, 1'b1,
        '{STAT_BAD_PIPE, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1, 4'd0, 1'b1, 1'b0}},
      '{'{ACT_PUSH_EMPTY, 8'hFF, 1'b1, 3'd0}, 6'd1, 1'b1,
        '{STAT_OK, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1, 4'd1, 1'b0, 1'b0}},
      '{'{ACT_PUSH_BYTE, 8'h00, 1'b0, 3'd7}, 6'd1, 1'b0, '0},
      '{'{ACT_PUSH_BYTE, 8'hFF, 1'b1, 3'd5}, 6'd1, 1'b1,
        '{STAT_OK, 8'h00, 1'b0, 3'd5, 6'd2, 1'b1, 4'd2, 1'b0, 1'b0}},
      '{'{ACT_PUSH_BYTE, 8'hA5, 1'b1, 3'd6}, 6'd1, 1'b1,
        '{STAT_BAD_PIPE, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1, 4'd2, 1'b0, 1'b0}},
      '{'{ACT_POP, 8'h00, 1'b0, 3'd0}, 6'd1, 1'b1,
        '{STAT_OK, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1, 4'd1, 1'b0, 1'b0}},
      '{'{ACT_POP, 8'h00, 1'b0, 3'd0}, 6'd1, 1'b0, '0},
      '{'{ACT_PUSH_BYTE, 8'h3C, 1'b0, 3'd0}, 6'd1, 1'b0, '0},
      '{'{ACT_PUSH_EMPTY, 8'h00, 1'b0, 3'd3}, 6'd1, 1'b1,
        '{STAT_OK, 8'h00, 1'b0, 3'd3, 6'd0, 1'b1, 4'd1, 1'b0, 1'b0}},
      '{'{ACT_NONE, 8'h5A, 1'b1, 3'd7}, 6'd1, 1'b0, '0},
      '{'{ACT_PUSH_BYTE, 8'h11, 1'b0, 3'd0}, 6'd32, 1'b0, '0},
      '{'{ACT_PUSH_BYTE, 8'h22, 1'b1, 3'd7}, 6'd1, 1'b1,
        '{STAT_TOO_LONG, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1, 4'd1, 1'b0, 1'b0}},
      '{'{ACT_PUSH_BYTE, 8'h5A, 1'b0, 3'd0}, 6'd31, 1'b0, '0},
      '{'{ACT_PUSH_BYTE, 8'hC3, 1'b1, 3'd1}, 6'd1, 1'b0, '0},
      '{'{ACT_PUSH_EMPTY, 8'h00, 1'b0, 3'd4}, 6'd6, 1'b0, '0},
      '{'{ACT_PUSH_EMPTY, 8'h00, 1'b0, 3'd0}, 6'd1, 1'b1,
        '{STAT_FULL, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1, 4'd8, 1'b0, 1'b1}},
      '{'{ACT_PUSH_BYTE, 8'h77, 1'b0, 3'd2}, 6'd1, 1'b0, '0},
      '{'{ACT_POP, 8'h00, 1'b0, 3'd0}, 6'd1, 1'b0, '0},
      '{'{ACT_PUSH_BYTE, 8'h88, 1'b1, 3'd0}, 6'd1, 1'b1,
        '{STAT_FULL, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1, 4'd7, 1'b0, 1'b0}},
      '{'{ACT_PUSH_BYTE, 8'h99, 1'b1, 3'd6}, 6'd1, 1'b1,
        '{STAT_BAD_PIPE, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1, 4'd7, 1'b0, 1'b0}},
      '{'{ACT_POP, 8'h00, 1'b0, 3'd0}, 6'd7, 1'b0, '0},
      '{'{ACT_POP, 8'h00, 1'b0, 3'd0}, 6'd1, 1'b1,
        '{STAT_EMPTY, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1, 4'd0, 1'b1, 1'b0}}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [7:0] slot_bytes [BYTE_DEPTH];
   logic [5:0] slot_len [SLOTS];
   logic [2:0] slot_tag [SLOTS];
   int         head_slot;
   int         tail_slot;
   int         held_msgs;
   int         fill_pos;
   logic       fill_overflow;
   logic       fill_dropped;

   rsp_type step_results [$];
   rsp_type awaited_results [$];
   rsp_type oldest;
   int      errors         = 0;
   int      cycle_count    = 0;
   int      results_seen   = 0;
   int      items_accepted = 0;
   logic    random_phase   = 1'b0;

   tagged_radio_message_fifo_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   function automatic rsp_type result_word(input status_type st, input logic [7:0] b,
                                           input logic bv, input logic [2:0] p,
                                           input logic [5:0] len, input logic fin);
      rsp_type r;
      r.status       = st;
      r.out_byte     = b;
      r.byte_valid   = bv;
      r.out_pipe     = p;
      r.msg_length   = len;
      r.run_end      = fin;
      r.queued_count = 4'(held_msgs);
      r.is_empty     = (held_msgs == 0);
      r.is_full      = (held_msgs >= SLOTS);
      return r;
   endfunction

   function automatic void close_message(input logic [2:0] p, input logic dropped,
                                         input logic too_long);
      status_type st;
      int         len;
      len = fill_pos;
      if (dropped || held_msgs >= SLOTS) st = STAT_FULL;
      else if (too_long) st = STAT_TOO_LONG;
      else if (int'(p) > PIPE_MAX) st = STAT_BAD_PIPE;
      else st = STAT_OK;
      fill_pos      = 0;
      fill_overflow = 1'b0;
      fill_dropped  = 1'b0;
      if (st != STAT_OK) begin
         step_results.push_back(result_word(st, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1));
      end else begin
         slot_len[tail_slot] = 6'(len);
         slot_tag[tail_slot] = p;
         tail_slot = (tail_slot + 1) % SLOTS;
         held_msgs++;
         step_results.push_back(result_word(STAT_OK, 8'h00, 1'b0, p, 6'(len), 1'b1));
      end
   endfunction

   function automatic void predict_fifo_results(input req_type item);
      int slot;
      int len;
      step_results.delete();
      case (item.action)
         ACT_PUSH_BYTE: begin
            if (held_msgs >= SLOTS) begin
               fill_dropped = 1'b1;
            end else if (fill_pos < MSG_BYTES) begin
               slot_bytes[tail_slot * MSG_BYTES + fill_pos] = item.data_byte;
               fill_pos++;
            end else begin
               fill_overflow = 1'b1;
            end
            if (item.last_byte) close_message(item.pipe, fill_dropped, fill_overflow);
         end
         ACT_PUSH_EMPTY: begin
            fill_pos      = 0;
            fill_overflow = 1'b0;
            fill_dropped  = 1'b0;
            close_message(item.pipe, 1'b0, 1'b0);
         end
         ACT_POP: begin
            if (held_msgs == 0) begin
               step_results.push_back(result_word(STAT_EMPTY, 8'h00, 1'b0, 3'd0, 6'd0, 1'b1));
            end else begin
               slot      = head_slot;
               len       = int'(slot_len[slot]);
               head_slot = (head_slot + 1) % SLOTS;
               held_msgs--;
               if (len == 0) begin
                  step_results.push_back(result_word(STAT_OK, 8'h00, 1'b0, slot_tag[slot],
                                                     6'd0, 1'b1));
               end else begin
                  for (int i = 0; i < len; i++) begin
                     step_results.push_back(result_word(STAT_OK,
                                                        slot_bytes[slot * MSG_BYTES + i],
                                                        1'b1, slot_tag[slot], 6'(len),
                                                        i == len - 1));
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int draw_wait(input logic calm);
      return calm ? 0 : int'($urandom_range(0, 16));
   endfunction

   function automatic logic [2:0] draw_pipe();
      return ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
   endfunction

   function automatic req_type make_req(input action_type act, input logic [7:0] b,
                                        input logic fin, input logic [2:0] p);
      req_type r;
      r.action    = act;
      r.data_byte = b;
      r.last_byte = fin;
      r.pipe      = p;
      return r;
   endfunction

   task automatic send_item(input req_type item, input logic typed, input rsp_type typed_result);
      int gap;
      gap = draw_wait(((items_accepted / 40) % 4) == 2);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_fifo_results(item);
      if (typed) begin
         awaited_results.push_back(typed_result);
      end else begin
         foreach (step_results[i]) awaited_results.push_back(step_results[i]);
      end
      if (item.action != ACT_NONE) items_accepted++;
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 100) $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   initial begin : stimulus
      int         pick;
      int         pop_weight;
      int         len;
      logic [2:0] tag;
      head_slot     = 0;
      tail_slot     = 0;
      held_msgs     = 0;
      fill_pos      = 0;
      fill_overflow = 1'b0;
      fill_dropped  = 1'b0;
      foreach (slot_bytes[i]) slot_bytes[i] = 8'h00;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ROWS; r++) begin
         repeat (int'(DIRECTED[r].reps)) begin
            send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);
         end
      end

      items_accepted = 0;
      random_phase   = 1'b1;
      while (items_accepted < RANDOM_ITEMS) begin
         pop_weight = ((items_accepted / 60) % 2 == 0) ? 3 : 9;
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            send_item(make_req(action_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))),
                      1'b0, '0);
         end else if (pick < 3 + pop_weight) begin
            send_item(make_req(ACT_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                               3'($urandom_range(0, 7))), 1'b0, '0);
         end else begin
            pick = $urandom_range(0, 19);
            if (pick < 16) len = $urandom_range(1, 5);
            else if (pick < 18) len = 0;
            else if (pick < 19) len = $urandom_range(29, 34);
            else len = MSG_BYTES;
            tag = draw_pipe();
            if (len == 0) begin
               send_item(make_req(ACT_PUSH_EMPTY, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), tag), 1'b0, '0);
            end else begin
               for (int k = 0; k < len; k++) begin
                  if ($urandom_range(0, 19) == 0) begin
                     send_item(make_req(ACT_POP, 8'h00, 1'b0, 3'd0), 1'b0, '0);
                  end
                  send_item(make_req(ACT_PUSH_BYTE, 8'($urandom_range(0, 255)), k == len - 1,
                                     (k == len - 1) ? tag : 3'($urandom_range(0, 7))),
                            1'b0, '0);
               end
            end
         end
      end
      req_valid <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : result_sink
      int   hold;
      logic long_done;
      long_done = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (random_phase && !long_done) begin
            hold      = LONG_HOLD;
            long_done = 1'b1;
         end else begin
            hold = draw_wait(((results_seen / 50) % 4) == 1);
         end
         repeat (hold) begin
            rsp_stall <= 1'b1;
            @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            errors++;
            if (errors <= 100) begin
               $display("%0t: expected no transaction, got %h", $time, rsp_data);
            end
         end else begin
            oldest = awaited_results.pop_front();
            check_field("status", 8'(oldest.status), 8'(rsp_data.status));
            check_field("out_byte", oldest.out_byte, rsp_data.out_byte);
            check_field("byte_valid", 8'(oldest.byte_valid), 8'(rsp_data.byte_valid));
            check_field("out_pipe", 8'(oldest.out_pipe), 8'(rsp_data.out_pipe));
            check_field("msg_length", 8'(oldest.msg_length), 8'(rsp_data.msg_length));
            check_field("run_end", 8'(oldest.run_end), 8'(rsp_data.run_end));
            check_field("queued_count", 8'(oldest.queued_count), 8'(rsp_data.queued_count));
            check_field("is_empty", 8'(oldest.is_empty), 8'(rsp_data.is_empty));
            check_field("is_full", 8'(oldest.is_full), 8'(rsp_data.is_full));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
